// ===== hdl/dzr_pkg.sv =====
// ----------------------------------------------------------------------------
// dzr_pkg
// Shared types and constants for the depth registration z-buffer scatter.
// ----------------------------------------------------------------------------
package dzr_pkg;

  localparam int FRAME_WIDTH   = 640;
  localparam int FRAME_HEIGHT  = 480;
  localparam int SHIFT_ENTRIES = 16384;

  localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int FRAME_AW     = $clog2(FRAME_PIXELS);
  localparam int SHIFT_AW     = $clog2(SHIFT_ENTRIES);

  // Signed width that holds every linear target and neighbour index.
  localparam int TGT_W = $clog2((512 + 1) * FRAME_WIDTH + 512 * FRAME_HEIGHT) + 1;

  localparam int DEPTH_W = 14;
  localparam int SHIFT_W = 16;
  localparam int COL_W   = 12;
  localparam int CFG_W   = 9;

  localparam int S_TDATA_W = 88;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 16;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_LOAD    = 2'd1,
    OP_SCATTER = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_NO_DEPTH = 2'd1,
    STAT_BOUNDS   = 2'd2,
    STAT_OCCLUDED = 2'd3
  } status_t;

  typedef enum logic {
    CFG_MIRROR_MODE     = 1'b0,
    CFG_PAD_START_LINES = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_SHIFT,
    ST_ADDR,
    ST_TGT,
    ST_LOOK,
    ST_NORTH,
    ST_NWEST,
    ST_WEST,
    ST_RESP
  } state_t;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic        [18:0] read_index;
    logic signed [15:0] shift_value;
    logic        [13:0] shift_index;
    logic        [8:0]  reg_y;
    logic signed [15:0] reg_x;
    logic        [13:0] depth_value;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [13:0] read_depth;
  } out_item_t;

endpackage

// ===== hdl/dzr_ram.sv =====
// ----------------------------------------------------------------------------
// dzr_ram
// Simple dual-port synchronous RAM: one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module dzr_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wen,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             ren,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/dzr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dzr_ctrl
// Operation sequencer: decodes items, runs the scatter read-modify-write on
// the frame store, sweeps the store clear and drives the result register.
// ----------------------------------------------------------------------------
module dzr_ctrl import dzr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [S_TUSER_W-1:0] s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 mirror_mode,
  input  logic [CFG_W-1:0]     pad_start_lines,
  output logic                 frame_wen,
  output logic [FRAME_AW-1:0]  frame_waddr,
  output logic [DEPTH_W-1:0]   frame_wdata,
  output logic                 frame_ren,
  output logic [FRAME_AW-1:0]  frame_raddr,
  input  logic [DEPTH_W-1:0]   frame_rdata,
  output logic                 shift_wen,
  output logic [SHIFT_AW-1:0]  shift_waddr,
  output logic [SHIFT_W-1:0]   shift_wdata,
  output logic                 shift_ren,
  output logic [SHIFT_AW-1:0]  shift_raddr,
  input  logic [SHIFT_W-1:0]   shift_rdata
);

  state_t state, state_next;

  in_item_t item;
  op_t      op;
  logic     clr_reply;

  logic [FRAME_AW-1:0] clr_addr;

  logic signed [SHIFT_W:0]  sum;
  logic signed [TGT_W-1:0]  row_base;
  logic signed [TGT_W-1:0]  pad_off;
  logic signed [TGT_W-1:0]  lin;
  logic signed [TGT_W-1:0]  tgt;
  logic [COL_W-1:0]         col;

  logic [COL_W-1:0]         col_comb;
  logic                     col_bad;
  logic signed [TGT_W-1:0]  lin_comb;
  logic signed [TGT_W-1:0]  tgt_comb;
  logic                     tgt_bad;
  logic signed [TGT_W-1:0]  nb_north;
  logic signed [TGT_W-1:0]  nb_nwest;
  logic signed [TGT_W-1:0]  nb_west;
  logic                     occluded;

  logic                     set_res;
  logic [DEPTH_W-1:0]       res_depth_in;
  status_t                  res_status_in;
  logic [DEPTH_W-1:0]       res_depth;
  status_t                  res_status;
  out_item_t                out_item;

  // Datapath helpers.
  assign col_comb = sum[SHIFT_W-1:4];
  assign col_bad  = sum[SHIFT_W] || (32'(col_comb) >= 32'(FRAME_WIDTH));
  assign lin_comb = mirror_mode ?
                    row_base + TGT_W'(FRAME_WIDTH - 2) - TGT_W'(col_comb) :
                    row_base + TGT_W'(col_comb);
  assign tgt_comb = lin - pad_off;
  assign tgt_bad  = tgt_comb[TGT_W-1] || (tgt_comb >= $signed(TGT_W'(FRAME_PIXELS)));
  assign nb_north = tgt - TGT_W'(FRAME_WIDTH);
  assign nb_nwest = tgt - TGT_W'(FRAME_WIDTH + 1);
  assign nb_west  = tgt - TGT_W'(1);
  assign occluded = (frame_rdata != '0) && (frame_rdata <= item.depth_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    frame_wen     = 1'b0;
    frame_waddr   = clr_addr;
    frame_wdata   = item.depth_value;
    frame_ren     = 1'b0;
    frame_raddr   = item.read_index[FRAME_AW-1:0];
    shift_wen     = 1'b0;
    shift_waddr   = SHIFT_AW'(32'(item.shift_index));
    shift_wdata   = item.shift_value;
    shift_ren     = 1'b0;
    shift_raddr   = SHIFT_AW'(32'(item.depth_value));
    set_res       = 1'b0;
    res_depth_in  = '0;
    res_status_in = STAT_DONE;
    case (state)
      ST_CLEAR: begin
        frame_wen   = 1'b1;
        frame_wdata = '0;
        if (clr_addr == FRAME_AW'(FRAME_PIXELS - 1)) begin
          if (clr_reply) begin
            set_res    = 1'b1;
            state_next = ST_RESP;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (op)
          OP_CLEAR: begin
            state_next = ST_CLEAR;
          end
          OP_LOAD: begin
            set_res    = 1'b1;
            state_next = ST_RESP;
            if (32'(item.shift_index) < 32'(SHIFT_ENTRIES)) begin
              shift_wen = 1'b1;
            end else begin
              res_status_in = STAT_BOUNDS;
            end
          end
          OP_SCATTER: begin
            if (item.depth_value == '0) begin
              set_res       = 1'b1;
              res_status_in = STAT_NO_DEPTH;
              state_next    = ST_RESP;
            end else if (32'(item.depth_value) >= 32'(SHIFT_ENTRIES)) begin
              set_res       = 1'b1;
              res_status_in = STAT_BOUNDS;
              state_next    = ST_RESP;
            end else begin
              shift_ren  = 1'b1;
              state_next = ST_SHIFT;
            end
          end
          OP_READ: begin
            if (32'(item.read_index) < 32'(FRAME_PIXELS)) begin
              frame_ren  = 1'b1;
              state_next = ST_RDWAIT;
            end else begin
              set_res       = 1'b1;
              res_status_in = STAT_BOUNDS;
              state_next    = ST_RESP;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_RDWAIT: begin
        set_res      = 1'b1;
        res_depth_in = frame_rdata;
        state_next   = ST_RESP;
      end
      ST_SHIFT: begin
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        if (col_bad) begin
          set_res       = 1'b1;
          res_status_in = STAT_BOUNDS;
          state_next    = ST_RESP;
        end else begin
          state_next = ST_TGT;
        end
      end
      ST_TGT: begin
        frame_raddr = tgt_comb[FRAME_AW-1:0];
        if (tgt_bad) begin
          set_res       = 1'b1;
          res_status_in = STAT_BOUNDS;
          state_next    = ST_RESP;
        end else begin
          frame_ren  = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        frame_waddr = tgt[FRAME_AW-1:0];
        if (occluded) begin
          set_res       = 1'b1;
          res_status_in = STAT_OCCLUDED;
          state_next    = ST_RESP;
        end else begin
          frame_wen  = 1'b1;
          state_next = ST_NORTH;
        end
      end
      ST_NORTH: begin
        frame_waddr = nb_north[FRAME_AW-1:0];
        frame_wen   = (item.reg_y != '0) && !nb_north[TGT_W-1];
        state_next  = ST_NWEST;
      end
      ST_NWEST: begin
        frame_waddr = nb_nwest[FRAME_AW-1:0];
        frame_wen   = (item.reg_y != '0) && (col != '0) && !nb_nwest[TGT_W-1];
        state_next  = ST_WEST;
      end
      ST_WEST: begin
        frame_waddr = nb_west[FRAME_AW-1:0];
        frame_wen   = (col != '0) && !nb_west[TGT_W-1];
        set_res     = 1'b1;
        state_next  = ST_RESP;
      end
      ST_RESP: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Item capture and scatter datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      item <= in_item_t'(s_tdata);
      op   <= op_t'(s_tuser);
    end
    if (state == ST_SHIFT) begin
      sum      <= $signed({item.reg_x[SHIFT_W-1], item.reg_x})
                + $signed({shift_rdata[SHIFT_W-1], shift_rdata});
      row_base <= $signed(TGT_W'(item.reg_y) * TGT_W'(FRAME_WIDTH));
      pad_off  <= $signed(TGT_W'(pad_start_lines) * TGT_W'(FRAME_HEIGHT));
    end
    if (state == ST_ADDR) begin
      col <= col_comb;
      lin <= lin_comb;
    end
    if (state == ST_TGT) begin
      tgt <= tgt_comb;
    end
    if (set_res) begin
      res_depth  <= res_depth_in;
      res_status <= res_status_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      clr_reply <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end else begin
        clr_addr <= '0;
      end
      if (state == ST_EXEC && op == OP_CLEAR) begin
        clr_reply <= 1'b1;
      end
    end
  end

  assign out_item.status     = res_status;
  assign out_item.read_depth = res_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_RESP && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP && (!m_tvalid || m_tready)) begin
      m_tdata <= M_TDATA_W'(out_item);
    end
  end

endmodule

// ===== hdl/depth_registration_zbuffer_scatter.sv =====
// ----------------------------------------------------------------------------
// depth_registration_zbuffer_scatter
// Reprojects depth pixels into the colour frame through a z-buffered store.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload
// s_*       in         tuser: operation; tdata: depth, reg_x, reg_y, shift
//                      index, shift value, read index
// m_*       out        tdata: read_depth, status
// cfg_*     in         register index and write data, no read-back
//
// One item is worked on at a time. A load, or any item rejected at decode,
// goes from decode straight to the result register; a read first waits for
// the registered frame store read. A scatter is paced by the single write
// port of the frame store, which writes the target and then its north,
// north-west and west neighbours in turn. A clear sweeps the frame store one
// entry a cycle over all FRAME_PIXELS entries, and the same sweep runs after
// reset before the first input transfer is taken. A result held on a stalled
// output does not stop the next input transfer from being taken.
//
module depth_registration_zbuffer_scatter import dzr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Input stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [13:0] depth_value, [29:14] reg_x, [38:30] reg_y, [52:39] shift_index,
  // [68:53] shift_value, [87:69] read_index
  input  logic [S_TDATA_W-1:0] s_tdata,
  // [1:0] operation
  input  logic [S_TUSER_W-1:0] s_tuser,
  // Result stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [13:0] read_depth, [15:14] status
  output logic [M_TDATA_W-1:0] m_tdata,
  // Configuration writes.
  input  logic                 cfg_wen,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic               mirror_mode;
  logic [CFG_W-1:0]   pad_start_lines;

  logic               frame_wen;
  logic [FRAME_AW-1:0] frame_waddr;
  logic [DEPTH_W-1:0] frame_wdata;
  logic               frame_ren;
  logic [FRAME_AW-1:0] frame_raddr;
  logic [DEPTH_W-1:0] frame_rdata;

  logic               shift_wen;
  logic [SHIFT_AW-1:0] shift_waddr;
  logic [SHIFT_W-1:0] shift_wdata;
  logic               shift_ren;
  logic [SHIFT_AW-1:0] shift_raddr;
  logic [SHIFT_W-1:0] shift_rdata;

  // Configuration registers: mirroring is on after reset, no padding.
  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_mode     <= 1'b1;
      pad_start_lines <= '0;
    end else if (cfg_wen) begin
      case (cfg_index_t'(cfg_index))
        CFG_MIRROR_MODE:     mirror_mode     <= cfg_data[0];
        CFG_PAD_START_LINES: pad_start_lines <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer: decode, scatter arithmetic, read-modify-write and clearing.
  dzr_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mirror_mode     (mirror_mode),
    .pad_start_lines (pad_start_lines),
    .frame_wen       (frame_wen),
    .frame_waddr     (frame_waddr),
    .frame_wdata     (frame_wdata),
    .frame_ren       (frame_ren),
    .frame_raddr     (frame_raddr),
    .frame_rdata     (frame_rdata),
    .shift_wen       (shift_wen),
    .shift_waddr     (shift_waddr),
    .shift_wdata     (shift_wdata),
    .shift_ren       (shift_ren),
    .shift_raddr     (shift_raddr),
    .shift_rdata     (shift_rdata)
  );

  // Frame store: the z-buffer itself, cleared by the sweep in the sequencer.
  dzr_ram #(
    .DEPTH (FRAME_PIXELS),
    .WIDTH (DEPTH_W)
  ) u_frame_ram (
    .clk   (clk),
    .wen   (frame_wen),
    .waddr (frame_waddr),
    .wdata (frame_wdata),
    .ren   (frame_ren),
    .raddr (frame_raddr),
    .rdata (frame_rdata)
  );

  // Depth-to-shift table; entries hold no value until loaded.
  dzr_ram #(
    .DEPTH (SHIFT_ENTRIES),
    .WIDTH (SHIFT_W)
  ) u_shift_ram (
    .clk   (clk),
    .wen   (shift_wen),
    .waddr (shift_waddr),
    .wdata (shift_wdata),
    .ren   (shift_ren),
    .raddr (shift_raddr),
    .rdata (shift_rdata)
  );

endmodule
